@@ design/ackodo_pkg.sv @@
// ----------------------------------------------------------------------------
// ackodo_pkg: shared types and constants for the odometry integrator
// Holds the multiplier operand types, CORDIC request/response structs, the
// sequencer state type and the arctangent table.
// ----------------------------------------------------------------------------
package ackodo_pkg;

    // CORDIC iteration count, capped at the table depth
    localparam int CORDIC_STEPS = 20;
    localparam int CORDIC_ITERS = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
    localparam logic [4:0] CORDIC_LAST = 5'(CORDIC_ITERS - 1);

    // CORDIC gain 0.6072529350 in Q.30
    localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
    // 1/(2*pi) in Q0.32, that is 2^32 / (2*pi)
    localparam logic [29:0] TURN_PER_RAD = 30'd683565276;

    // register reset values
    localparam logic signed [15:0] SPEED_RESET = 16'sd2048;
    localparam logic signed [23:0] CURV_RESET  = 24'sd40668;

    // configuration register indexes
    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CURVATURE = 4'd1;

    typedef logic signed [32:0] op_t;
    typedef logic signed [65:0] prod_t;

    typedef struct packed {
        logic        start;
        logic [31:0] angle;
    } cordic_req_t;

    typedef struct packed {
        logic done;
        op_t  cos_val;
        op_t  sin_val;
    } cordic_rsp_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_D,
        ST_ALO,
        ST_AHI,
        ST_A,
        ST_KLO,
        ST_KHI,
        ST_T,
        ST_CINIT,
        ST_CORDIC,
        ST_PX,
        ST_PY,
        ST_VX,
        ST_VY,
        ST_W,
        ST_WC
    } state_t;

    // arctangent of 2^-i as a binary angle
    function automatic logic [31:0] atan_lut(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            5'd24:   v = 32'd41;
            5'd25:   v = 32'd20;
            5'd26:   v = 32'd10;
            5'd27:   v = 32'd5;
            5'd28:   v = 32'd3;
            5'd29:   v = 32'd1;
            5'd30:   v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

@@ design/ackodo_mul.sv @@
// ----------------------------------------------------------------------------
// ackodo_mul: shared signed multiplier
// One 33x33 signed multiply per cycle, product registered.
// ----------------------------------------------------------------------------
module ackodo_mul (
    input  logic            clk,
    input  ackodo_pkg::op_t a,
    input  ackodo_pkg::op_t b,
    output ackodo_pkg::prod_t prod
);

    ackodo_pkg::prod_t prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= ackodo_pkg::prod_t'(a) * ackodo_pkg::prod_t'(b);
    end

    assign prod = prod_reg;

endmodule

@@ design/ackodo_cordic.sv @@
// ----------------------------------------------------------------------------
// ackodo_cordic: iterative rotation-mode CORDIC
// One shift-add iteration per cycle; returns cos and sin in Q.30.
// ----------------------------------------------------------------------------
module ackodo_cordic (
    input  logic                    clk,
    input  logic                    rst_n,
    input  ackodo_pkg::cordic_req_t req,
    output ackodo_pkg::cordic_rsp_t rsp
);

    logic            busy_reg;
    logic            done_reg;
    logic [4:0]      cnt_reg;
    logic            neg_reg;
    ackodo_pkg::op_t x_reg;
    ackodo_pkg::op_t y_reg;
    ackodo_pkg::op_t z_reg;

    logic            fold;
    logic [31:0]     folded;
    ackodo_pkg::op_t dx;
    ackodo_pkg::op_t dy;
    ackodo_pkg::op_t step_ang;

    // fold the angle into [-1/4, 1/4) turn
    assign fold   = (req.angle[31:30] == 2'b01) || (req.angle[31:30] == 2'b10);
    assign folded = fold ? {~req.angle[31], req.angle[30:0]} : req.angle;

    assign dx       = y_reg >>> cnt_reg;
    assign dy       = x_reg >>> cnt_reg;
    assign step_ang = ackodo_pkg::op_t'({1'b0, ackodo_pkg::atan_lut(cnt_reg)});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == ackodo_pkg::CORDIC_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            neg_reg <= fold;
            x_reg   <= ackodo_pkg::CORDIC_GAIN;
            y_reg   <= '0;
            z_reg   <= ackodo_pkg::op_t'({folded[31], folded});
        end
        else if (busy_reg)
        begin
            if (!z_reg[32])
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - step_ang;
            end
            else
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + step_ang;
            end
        end
    end

    assign rsp.done    = done_reg;
    assign rsp.cos_val = neg_reg ? -x_reg : x_reg;
    assign rsp.sin_val = neg_reg ? -y_reg : y_reg;

endmodule

@@ design/ackermann_odometry_integrator.sv @@
// ----------------------------------------------------------------------------
// ackermann_odometry_integrator: fixed-point bicycle-model dead reckoning
// Integrates one time step per request: distance, heading change, mid-step
// cos/sin by CORDIC, saturating position update and velocity outputs.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake              Payload
// in        sink       in_valid / in_ready    time_step
// out       source     out_valid / out_ready  x_out, y_out, heading_out,
//                                             vel_x, vel_y, turn_rate
// cfg       sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A request runs through the sequencer from acceptance until its result is
// loaded into the output register, the CORDIC step count capped at 32;
// in_ready is high only while the sequencer is idle, so a new request is
// taken only after the previous one has left the sequencer. The pace is
// set by the single shared multiplier (ten products in sequence) and the
// one-iteration-per-cycle CORDIC. Reset restores speed and curvature to their
// defaults and clears the pose. If the previous result is still unclaimed at
// the end, hold the finished result in the sequencer until the output frees.
// cfg_ready is always high; write only while idle.
// ----------------------------------------------------------------------------
module ackermann_odometry_integrator (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [23:0]                        time_step,

    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [31:0]                 x_out,
    output logic signed [31:0]                 y_out,
    output logic [31:0]                        heading_out,
    output logic signed [15:0]                 vel_x,
    output logic signed [15:0]                 vel_y,
    output logic signed [23:0]                 turn_rate,

    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ackodo_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [23:0]                        cfg_data
);

    // ------------------------------------------------------------------
    // saturation helpers
    // ------------------------------------------------------------------
    function automatic logic signed [31:0] sat32(input logic [32:0] v);
        logic signed [31:0] r;
        if (v[32] != v[31])
            r = v[32] ? 32'sh80000000 : 32'sh7fffffff;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [15:0] sat16(input logic [18:0] v);
        logic signed [15:0] r;
        if ((v[18:15] != 4'b0000) && (v[18:15] != 4'b1111))
            r = v[18] ? 16'sh8000 : 16'sh7fff;
        else
            r = v[15:0];
        return r;
    endfunction

    function automatic logic signed [23:0] sat24(input logic [27:0] v);
        logic signed [23:0] r;
        if ((v[27:23] != 5'b00000) && (v[27:23] != 5'b11111))
            r = v[27] ? 24'sh800000 : 24'sh7fffff;
        else
            r = v[23:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // state
    // ------------------------------------------------------------------
    ackodo_pkg::state_t state_reg;
    ackodo_pkg::state_t state_next;

    // configuration and pose
    logic signed [15:0] speed_reg;
    logic signed [23:0] curv_reg;
    logic signed [31:0] pos_x_reg;
    logic signed [31:0] pos_y_reg;
    logic [31:0]        heading_reg;

    // per-request working registers
    logic [23:0]        dt_reg;
    logic [39:0]        d_reg;      // speed*dt, Q.32 m
    logic [47:0]        alo_reg;    // low partial of d*curvature
    logic [63:0]        a_reg;      // d*curvature, Q.48 rad
    logic [31:0]        klo_reg;    // high word of a_low*TURN_PER_RAD
    logic [31:0]        dth_reg;
    logic [31:0]        half_reg;
    ackodo_pkg::op_t    c_reg;
    ackodo_pkg::op_t    s_reg;
    logic signed [15:0] vx_reg;
    logic signed [15:0] vy_reg;

    // output register
    logic               out_valid_reg;
    logic signed [31:0] x_out_reg;
    logic signed [31:0] y_out_reg;
    logic [31:0]        heading_out_reg;
    logic signed [15:0] vel_x_reg;
    logic signed [15:0] vel_y_reg;
    logic signed [23:0] turn_rate_reg;

    // shared units
    ackodo_pkg::op_t         mul_a;
    ackodo_pkg::op_t         mul_b;
    ackodo_pkg::prod_t       prod;
    ackodo_pkg::cordic_req_t cordic_req;
    ackodo_pkg::cordic_rsp_t cordic_rsp;

    logic        out_free;
    logic [48:0] t_low;
    logic [63:0] a_sum;
    logic [32:0] pos_sum;
    logic [31:0] dq;

    ackodo_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    ackodo_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (cordic_req),
        .rsp   (cordic_rsp)
    );

    assign out_free = !out_valid_reg || out_ready;
    assign dq       = d_reg[39:8];

    // d*curvature from its two partial products
    assign a_sum = {prod[39:0], 24'b0} + {{16{alo_reg[47]}}, alo_reg};

    // low bits of a*TURN_PER_RAD / 2^32; only bits 16..48 are needed
    assign t_low = prod[48:0] + {17'b0, klo_reg};

    // position update shared by the x and y steps
    assign pos_sum = (state_reg == ackodo_pkg::ST_PY)
        ? {pos_x_reg[31], pos_x_reg} + {{5{prod[65]}}, prod[65:38]}
        : {pos_y_reg[31], pos_y_reg} + {{5{prod[65]}}, prod[65:38]};

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ackodo_pkg::ST_IDLE:
            begin
                if (in_valid)
                    state_next = ackodo_pkg::ST_D;
            end
            ackodo_pkg::ST_D:      state_next = ackodo_pkg::ST_ALO;
            ackodo_pkg::ST_ALO:    state_next = ackodo_pkg::ST_AHI;
            ackodo_pkg::ST_AHI:    state_next = ackodo_pkg::ST_A;
            ackodo_pkg::ST_A:      state_next = ackodo_pkg::ST_KLO;
            ackodo_pkg::ST_KLO:    state_next = ackodo_pkg::ST_KHI;
            ackodo_pkg::ST_KHI:    state_next = ackodo_pkg::ST_T;
            ackodo_pkg::ST_T:      state_next = ackodo_pkg::ST_CINIT;
            ackodo_pkg::ST_CINIT:  state_next = ackodo_pkg::ST_CORDIC;
            ackodo_pkg::ST_CORDIC:
            begin
                if (cordic_rsp.done)
                    state_next = ackodo_pkg::ST_PX;
            end
            ackodo_pkg::ST_PX:     state_next = ackodo_pkg::ST_PY;
            ackodo_pkg::ST_PY:     state_next = ackodo_pkg::ST_VX;
            ackodo_pkg::ST_VX:     state_next = ackodo_pkg::ST_VY;
            ackodo_pkg::ST_VY:     state_next = ackodo_pkg::ST_W;
            ackodo_pkg::ST_W:      state_next = ackodo_pkg::ST_WC;
            ackodo_pkg::ST_WC:
            begin
                if (out_free)
                    state_next = ackodo_pkg::ST_IDLE;
            end
            default:               state_next = ackodo_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // sequencer outputs: multiplier operands, CORDIC start, ready
    // ------------------------------------------------------------------
    always_comb
    begin
        in_ready         = 1'b0;
        mul_a            = '0;
        mul_b            = '0;
        cordic_req.start = 1'b0;
        cordic_req.angle = heading_reg + half_reg;
        case (state_reg)
            ackodo_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ackodo_pkg::ST_D:
            begin
                mul_a = {{17{speed_reg[15]}}, speed_reg};
                mul_b = {9'b0, dt_reg};
            end
            ackodo_pkg::ST_ALO:
            begin
                mul_a = {9'b0, prod[23:0]};
                mul_b = {{9{curv_reg[23]}}, curv_reg};
            end
            ackodo_pkg::ST_AHI:
            begin
                mul_a = {{17{d_reg[39]}}, d_reg[39:24]};
                mul_b = {{9{curv_reg[23]}}, curv_reg};
            end
            ackodo_pkg::ST_KLO:
            begin
                mul_a = {1'b0, a_reg[31:0]};
                mul_b = {3'b0, ackodo_pkg::TURN_PER_RAD};
            end
            ackodo_pkg::ST_KHI:
            begin
                mul_a = {a_reg[63], a_reg[63:32]};
                mul_b = {3'b0, ackodo_pkg::TURN_PER_RAD};
            end
            ackodo_pkg::ST_CINIT:
            begin
                cordic_req.start = 1'b1;
            end
            ackodo_pkg::ST_PX:
            begin
                mul_a = {dq[31], dq};
                mul_b = c_reg;
            end
            ackodo_pkg::ST_PY:
            begin
                mul_a = {dq[31], dq};
                mul_b = s_reg;
            end
            ackodo_pkg::ST_VX:
            begin
                mul_a = {{17{speed_reg[15]}}, speed_reg};
                mul_b = c_reg;
            end
            ackodo_pkg::ST_VY:
            begin
                mul_a = {{17{speed_reg[15]}}, speed_reg};
                mul_b = s_reg;
            end
            // keep the turn-rate product steady while the result waits
            ackodo_pkg::ST_W, ackodo_pkg::ST_WC:
            begin
                mul_a = {{17{speed_reg[15]}}, speed_reg};
                mul_b = {{9{curv_reg[23]}}, curv_reg};
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // control, configuration, pose and output valid
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ackodo_pkg::ST_IDLE;
            speed_reg     <= ackodo_pkg::SPEED_RESET;
            curv_reg      <= ackodo_pkg::CURV_RESET;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            heading_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // register writes; drop unknown indexes
            if (cfg_valid)
            begin
                case (cfg_index)
                    ackodo_pkg::REG_SPEED:     speed_reg <= cfg_data[15:0];
                    ackodo_pkg::REG_CURVATURE: curv_reg  <= cfg_data;
                    default:                   curv_reg  <= curv_reg;
                endcase
            end

            // advance the pose once per request
            if (state_reg == ackodo_pkg::ST_PX)
                heading_reg <= heading_reg + dth_reg;
            if (state_reg == ackodo_pkg::ST_PY)
                pos_x_reg <= sat32(pos_sum);
            if (state_reg == ackodo_pkg::ST_VX)
                pos_y_reg <= sat32(pos_sum);

            if ((state_reg == ackodo_pkg::ST_WC) && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // working registers and output payload
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ackodo_pkg::ST_IDLE:
            begin
                if (in_valid)
                    dt_reg <= time_step;
            end
            ackodo_pkg::ST_ALO:
            begin
                d_reg <= prod[39:0];
            end
            ackodo_pkg::ST_AHI:
            begin
                alo_reg <= prod[47:0];
            end
            ackodo_pkg::ST_A:
            begin
                a_reg <= a_sum;
            end
            ackodo_pkg::ST_KHI:
            begin
                klo_reg <= prod[63:32];
            end
            ackodo_pkg::ST_T:
            begin
                dth_reg  <= t_low[47:16];
                half_reg <= t_low[48:17];
            end
            ackodo_pkg::ST_CORDIC:
            begin
                if (cordic_rsp.done)
                begin
                    c_reg <= cordic_rsp.cos_val;
                    s_reg <= cordic_rsp.sin_val;
                end
            end
            ackodo_pkg::ST_VY:
            begin
                vx_reg <= sat16(prod[48:30]);
            end
            ackodo_pkg::ST_W:
            begin
                vy_reg <= sat16(prod[48:30]);
            end
            ackodo_pkg::ST_WC:
            begin
                if (out_free)
                begin
                    x_out_reg       <= pos_x_reg;
                    y_out_reg       <= pos_y_reg;
                    heading_out_reg <= heading_reg;
                    vel_x_reg       <= vx_reg;
                    vel_y_reg       <= vy_reg;
                    turn_rate_reg   <= sat24(prod[39:12]);
                end
            end
            default:
            begin
                dt_reg <= dt_reg;
            end
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign x_out       = x_out_reg;
    assign y_out       = y_out_reg;
    assign heading_out = heading_out_reg;
    assign vel_x       = vel_x_reg;
    assign vel_y       = vel_y_reg;
    assign turn_rate   = turn_rate_reg;

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the Ackermann odometry integrator
// Drives time-step requests under random source and sink idling and register
// changes between phases, predicts every pose and velocity result with a
// bit-exact fixed-point model kept here, and compares each result as it
// leaves the block.
// ----------------------------------------------------------------------------
module tb;

    // Quiet limit: the slowest legal gap between two handshakes is the long
    // sink hold (LONG_HOLD) plus one request, a source gap and a sink stall.
    // 4000 covers that several times over.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD      = 400;
    localparam int DRAIN_CYCLES   = 80;

    localparam logic [23:0] STEP_MAX = 24'hFFFFFF;
    // Binary-angle advance per time unit at full speed and unit curvature
    localparam int TURN_PER_STEP = 5215;

    // Indexes the block does not decode; writes there must change nothing
    localparam logic [ackodo_pkg::CFG_IDX_W-1:0] REG_UNUSED_LO = 4'd2;
    localparam logic [ackodo_pkg::CFG_IDX_W-1:0] REG_UNUSED_HI = 4'd15;

    localparam int     ROT_STEPS   = (ackodo_pkg::CORDIC_STEPS > 32) ? 32
                                                                     : ackodo_pkg::CORDIC_STEPS;
    localparam longint ROT_GAIN    = 64'sd652032874;
    localparam longint RAD_TO_TURN = 64'sd683565276;
    localparam longint POS_MIN     = -64'sd2147483648;
    localparam longint POS_MAX     = 64'sd2147483647;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] hdg;
        logic [15:0] vx;
        logic [15:0] vy;
        logic [23:0] w;
    } odo_result_t;

    // ------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------
    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    logic [23:0]          time_step = 24'd0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic signed [31:0]   x_out;
    logic signed [31:0]   y_out;
    logic [31:0]          heading_out;
    logic signed [15:0]   vel_x;
    logic signed [15:0]   vel_y;
    logic signed [23:0]   turn_rate;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [ackodo_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [23:0]          cfg_data  = 24'd0;

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    logic [23:0] step_queue[$];       // time steps waiting for the driver
    odo_result_t expected_poses[$];   // predicted results, oldest first
    int          steps_queued   = 0;
    int          steps_accepted = 0;
    int          results_seen   = 0;
    int          errors         = 0;
    // 0 turns idling off on both sides; otherwise 1-in-N chance per cycle
    int          idle_odds      = 4;

    // Predictor copy of registers and pose
    logic signed [15:0] cur_speed   = ackodo_pkg::SPEED_RESET;
    logic signed [23:0] cur_curv    = ackodo_pkg::CURV_RESET;
    longint             est_x       = 0;
    longint             est_y       = 0;
    logic [31:0]        est_heading = 32'd0;

    // atan(2^-i) as a binary angle
    logic [31:0] arctan_turn [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    ackermann_odometry_integrator uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .time_step   (time_step),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .x_out       (x_out),
        .y_out       (y_out),
        .heading_out (heading_out),
        .vel_x       (vel_x),
        .vel_y       (vel_y),
        .turn_rate   (turn_rate),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // 8 ns period
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Rotation-mode CORDIC; fold the angle into [-1/4, 1/4) turn first and
    // flip the signs back afterwards
    function automatic void mid_trig(input logic [31:0] ang,
                                     output longint cos_q30, output longint sin_q30);
        logic        flip;
        logic [31:0] folded;
        longint      cx, cy, cz, dx, dy;
        flip   = (ang[31:30] == 2'b01) || (ang[31:30] == 2'b10);
        folded = flip ? ang + 32'h8000_0000 : ang;
        cz     = longint'(signed'(folded));
        cx     = ROT_GAIN;
        cy     = 0;
        for (int i = 0; i < ROT_STEPS; i++)
        begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cz >= 0)
            begin
                cx = cx - dx;
                cy = cy + dy;
                cz = cz - longint'(arctan_turn[i]);
            end
            else
            begin
                cx = cx + dx;
                cy = cy - dy;
                cz = cz + longint'(arctan_turn[i]);
            end
        end
        cos_q30 = flip ? -cx : cx;
        sin_q30 = flip ? -cy : cy;
    endfunction

    // Advance the predicted pose by one time step and return the result
    function automatic odo_result_t integrate_step(input logic [23:0] dt);
        longint      travel, arc, arc_hi, turn, cos_q30, sin_q30, dq, vx, vy, w;
        logic [63:0] arc_lo_prod;
        logic [31:0] dth, half;
        odo_result_t r;
        travel      = longint'(cur_speed) * longint'(dt);
        arc         = travel * longint'(cur_curv);
        // scale radians to binary angle without losing the low word
        arc_hi      = arc >>> 32;
        arc_lo_prod = {32'd0, arc[31:0]} * RAD_TO_TURN;
        turn        = arc_hi * RAD_TO_TURN + longint'(arc_lo_prod >> 32);
        dth         = turn[47:16];
        half        = turn[48:17];
        mid_trig(est_heading + half, cos_q30, sin_q30);
        dq          = travel >>> 8;
        est_x       = clamp(est_x + ((dq * cos_q30) >>> 38), POS_MIN, POS_MAX);
        est_y       = clamp(est_y + ((dq * sin_q30) >>> 38), POS_MIN, POS_MAX);
        est_heading = est_heading + dth;
        vx = clamp((longint'(cur_speed) * cos_q30) >>> 30, -32768, 32767);
        vy = clamp((longint'(cur_speed) * sin_q30) >>> 30, -32768, 32767);
        w  = clamp((longint'(cur_speed) * longint'(cur_curv)) >>> 12, -8388608, 8388607);
        r.x   = est_x[31:0];
        r.y   = est_y[31:0];
        r.hdg = est_heading;
        r.vx  = vx[15:0];
        r.vy  = vy[15:0];
        r.w   = w[23:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Reporting
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        errors++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got %h, want %h",
                                      results_seen, name, got, want));
    endtask

    // ------------------------------------------------------------------
    // Driver: offer queued time steps; hold valid and payload until the
    // request is taken, then predict its result
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : step_driver
        int in_gap;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                expected_poses.push_back(integrate_step(time_step));
                steps_accepted++;
            end
            if (!in_valid || in_ready)
            begin
                if (in_gap != 0)
                begin
                    in_gap--;
                    in_valid <= 1'b0;
                end
                else if (step_queue.size() == 0)
                    in_valid <= 1'b0;
                else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
                begin
                    // drop valid for a burst of random length
                    in_gap = $urandom_range(0, 8);
                    in_valid <= 1'b0;
                end
                else
                begin
                    in_valid  <= 1'b1;
                    time_step <= step_queue.pop_front();
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each result against the oldest prediction and pace
    // out_ready with random stalls plus a few long hold-offs
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : pose_monitor
        odo_result_t want;
        int          out_gap;
        int          hold_left;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (expected_poses.size() == 0)
                    report_mismatch($sformatf("result %0d with no request pending",
                                              results_seen));
                else
                begin
                    want = expected_poses.pop_front();
                    compare_field("x_out",       x_out,             want.x);
                    compare_field("y_out",       y_out,             want.y);
                    compare_field("heading_out", heading_out,       want.hdg);
                    compare_field("vel_x",       {16'd0, vel_x},    {16'd0, want.vx});
                    compare_field("vel_y",       {16'd0, vel_y},    {16'd0, want.vy});
                    compare_field("turn_rate",   {8'd0, turn_rate}, {8'd0, want.w});
                end
                // hold off long enough for the block to fill and stall its input
                if (results_seen == 40 || results_seen == 1100)
                    hold_left = LONG_HOLD;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (out_gap != 0)
            begin
                out_gap--;
                out_ready <= 1'b0;
            end
            else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
            begin
                out_gap = $urandom_range(0, 8);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run if no handshake of any kind happens for too long
    // ------------------------------------------------------------------
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else if (rst_n)
                quiet_cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_step(input logic [23:0] dt);
        step_queue.push_back(dt);
        steps_queued++;
    endtask

    // Wait until every queued request has been taken and answered
    task automatic drain();
        while (steps_accepted != steps_queued || expected_poses.size() != 0)
            @(posedge clk);
    endtask

    // Write one register; only called while the block is idle
    task automatic write_reg(input logic [ackodo_pkg::CFG_IDX_W-1:0] idx,
                             input logic [23:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == ackodo_pkg::REG_SPEED)
            cur_speed = data[15:0];
        else if (idx == ackodo_pkg::REG_CURVATURE)
            cur_curv = data;
    endtask

    // Turn to a target heading in one step at full speed, unit curvature
    task automatic steer_to(input logic [31:0] target);
        logic [31:0] delta;
        write_reg(ackodo_pkg::REG_SPEED, 24'h007FFF);
        write_reg(ackodo_pkg::REG_CURVATURE, 24'd65536);
        delta = target - est_heading;
        queue_step(24'(delta / TURN_PER_STEP));
        drain();
        write_reg(ackodo_pkg::REG_CURVATURE, 24'd0);
    endtask

    function automatic logic [23:0] random_step();
        case ($urandom_range(0, 7))
            0:       return 24'd0;
            1:       return STEP_MAX;
            2:       return 24'($urandom_range(0, 255));
            3, 4:    return 24'($urandom_range(0, 65535));
            default: return 24'($urandom);
        endcase
    endfunction

    // Random register setting, extremes weighted in; upper data bits of a
    // speed write are junk the block must ignore
    task automatic pick_config();
        logic [15:0] spd;
        logic [23:0] crv;
        logic [7:0]  junk;
        junk = 8'($urandom);
        case ($urandom_range(0, 4))
            0:       spd = 16'h7FFF;
            1:       spd = 16'h8000;
            2:       spd = 16'($urandom_range(0, 8192));
            default: spd = 16'($urandom);
        endcase
        case ($urandom_range(0, 5))
            0:       crv = 24'h7FFFFF;
            1:       crv = 24'h800000;
            2:       crv = 24'd0;
            3:       crv = 24'($urandom_range(0, 131071));
            4:       crv = -24'($urandom_range(0, 131071));
            default: crv = 24'($urandom);
        endcase
        if ($urandom_range(0, 3) == 0)
            write_reg(REG_UNUSED_LO + 4'($urandom_range(0, 13)), 24'($urandom));
        write_reg(ackodo_pkg::REG_SPEED, {junk, spd});
        write_reg(ackodo_pkg::REG_CURVATURE, crv);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int n_phase;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Reset registers: zero step, field extremes, alternating bits
        queue_step(24'd0);
        queue_step(24'd1);
        queue_step(24'd2);
        queue_step(STEP_MAX);
        queue_step(24'h800000);
        queue_step(24'h555555);
        queue_step(24'hAAAAAA);
        queue_step(24'd1000);
        drain();

        // Largest speed and curvature: turn rate saturates, heading wraps
        write_reg(ackodo_pkg::REG_SPEED, 24'hFF7FFF);
        write_reg(ackodo_pkg::REG_CURVATURE, 24'h7FFFFF);
        queue_step(STEP_MAX);
        queue_step(STEP_MAX);
        queue_step(24'd0);
        queue_step(24'd1);
        drain();

        // Most negative speed and curvature
        write_reg(ackodo_pkg::REG_SPEED, 24'h008000);
        write_reg(ackodo_pkg::REG_CURVATURE, 24'h800000);
        queue_step(STEP_MAX);
        queue_step(24'd1);
        queue_step(24'd0);
        drain();

        // Writes to undecoded indexes must leave the registers alone
        write_reg(REG_UNUSED_LO, 24'h5A5A5A);
        write_reg(REG_UNUSED_HI, 24'hFFFFFF);
        queue_step(STEP_MAX);
        queue_step(24'h123456);
        drain();

        // Standing still: pose frozen, velocities zero
        write_reg(ackodo_pkg::REG_SPEED, 24'd0);
        write_reg(ackodo_pkg::REG_CURVATURE, 24'h7FFFFF);
        queue_step(24'h654321);
        drain();

        // Face +y, then drive straight into positive y saturation
        steer_to(32'h4000_0000);
        write_reg(ackodo_pkg::REG_SPEED, 24'h007FFF);
        for (int i = 0; i < 290; i++)
            queue_step(STEP_MAX - 24'($urandom_range(0, 4095)));
        drain();

        // Reverse at full speed through zero into negative saturation, no idling
        idle_odds = 0;
        write_reg(ackodo_pkg::REG_SPEED, 24'h008000);
        for (int i = 0; i < 540; i++)
            queue_step(STEP_MAX - 24'($urandom_range(0, 4095)));
        drain();

        // Face +x and run into positive x saturation
        idle_odds = 3;
        steer_to(32'h0000_0000);
        write_reg(ackodo_pkg::REG_SPEED, 24'h007FFF);
        for (int i = 0; i < 290; i++)
            queue_step(STEP_MAX - 24'($urandom_range(0, 4095)));
        drain();

        // Random settings and steps; the last phase runs without idling
        n_phase = 6;
        for (int p = 0; p < n_phase; p++)
        begin
            if (p == n_phase - 1)
                idle_odds = 0;
            else
                case ($urandom_range(0, 2))
                    0:       idle_odds = 0;
                    1:       idle_odds = 2;
                    default: idle_odds = 5;
                endcase
            pick_config();
            for (int i = 0; i < 95; i++)
                queue_step(random_step());
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_poses.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_poses.size()));
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
